FILE: src/suc_pkg.sv
// Shared types, constants and tables of the sound unit control block.
`timescale 1ns / 1ps
`default_nettype none
package suc_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [4:0] REG_P0_CTRL  = 5'h00;
	localparam logic [4:0] REG_P0_SWEEP = 5'h01;
	localparam logic [4:0] REG_P0_LO    = 5'h02;
	localparam logic [4:0] REG_P0_HI    = 5'h03;
	localparam logic [4:0] REG_P1_CTRL  = 5'h04;
	localparam logic [4:0] REG_P1_SWEEP = 5'h05;
	localparam logic [4:0] REG_P1_LO    = 5'h06;
	localparam logic [4:0] REG_P1_HI    = 5'h07;
	localparam logic [4:0] REG_TRI_LIN  = 5'h08;
	localparam logic [4:0] REG_TRI_LO   = 5'h0A;
	localparam logic [4:0] REG_TRI_HI   = 5'h0B;
	localparam logic [4:0] REG_NS_CTRL  = 5'h0C;
	localparam logic [4:0] REG_NS_PER   = 5'h0E;
	localparam logic [4:0] REG_NS_LEN   = 5'h0F;
	localparam logic [4:0] REG_STATUS   = 5'h15;
	localparam logic [4:0] REG_FRAME    = 5'h17;

	localparam logic [14:0] Q1_STEP   = 15'd3729;
	localparam logic [14:0] Q2_STEP   = 15'd7457;
	localparam logic [14:0] Q3_STEP   = 15'd11186;
	localparam logic [14:0] END4_STEP = 15'd14915;
	localparam logic [14:0] END5_STEP = 15'd18641;
	localparam logic [15:0] PERIOD_MAX = 16'h07FF;
	localparam logic [3:0]  LEVEL_FULL = 4'hF;

	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  reg_offset;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        irq_pulse;
		logic [10:0] pulse_a_period;
		logic [10:0] pulse_b_period;
		logic [1:0]  pulse_a_duty;
		logic [1:0]  pulse_b_duty;
		logic [3:0]  pulse_a_volume;
		logic [3:0]  pulse_b_volume;
		logic [10:0] tri_period;
		logic        tri_active;
		logic [11:0] noise_period;
		logic [3:0]  noise_volume;
	} rsp_t;

	// quarter and half frame strobes from the sequencer
	typedef struct packed {
		logic quarter;
		logic half;
	} frame_clk_t;

	function automatic logic [7:0] length_lookup(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0: r = 8'd10;   5'd1: r = 8'd254; 5'd2: r = 8'd20;  5'd3: r = 8'd2;
			5'd4: r = 8'd40;   5'd5: r = 8'd4;   5'd6: r = 8'd80;  5'd7: r = 8'd6;
			5'd8: r = 8'd160;  5'd9: r = 8'd8;   5'd10: r = 8'd60; 5'd11: r = 8'd10;
			5'd12: r = 8'd14;  5'd13: r = 8'd12; 5'd14: r = 8'd26; 5'd15: r = 8'd14;
			5'd16: r = 8'd12;  5'd17: r = 8'd16; 5'd18: r = 8'd24; 5'd19: r = 8'd18;
			5'd20: r = 8'd48;  5'd21: r = 8'd20; 5'd22: r = 8'd96; 5'd23: r = 8'd22;
			5'd24: r = 8'd192; 5'd25: r = 8'd24; 5'd26: r = 8'd72; 5'd27: r = 8'd26;
			5'd28: r = 8'd16;  5'd29: r = 8'd28; 5'd30: r = 8'd32; default: r = 8'd30;
		endcase
		return r;
	endfunction

	function automatic logic [11:0] noise_lookup(input logic [3:0] idx);
		logic [11:0] r;
		case (idx)
			4'd0: r = 12'd4;     4'd1: r = 12'd8;     4'd2: r = 12'd16;   4'd3: r = 12'd32;
			4'd4: r = 12'd64;    4'd5: r = 12'd96;    4'd6: r = 12'd128;  4'd7: r = 12'd160;
			4'd8: r = 12'd202;   4'd9: r = 12'd254;   4'd10: r = 12'd380; 4'd11: r = 12'd508;
			4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034;
			default: r = 12'd4068;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/suc_stream_if.sv
// Valid/ready channel carrying one request or response payload.
`timescale 1ns / 1ps
`default_nettype none
interface suc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/suc_frame_seq.sv
// Frame sequencer: counter, mode, quarter/half strobes and interrupt.
`timescale 1ns / 1ps
`default_nettype none
module suc_frame_seq
	import suc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tick,
	input  wire logic       frame_wr,
	input  wire logic [7:0] wdata,
	output frame_clk_t      fclk,
	output logic            irq_set,
	output logic            irq_inhibit_wr
);
	logic [14:0] count_q;
	logic [7:0]  mode_q;
	logic [14:0] cnt_inc;
	logic [14:0] last_step;
	logic        hit;

	always_comb begin
		cnt_inc   = count_q + 15'd1;
		last_step = mode_q[7] ? END5_STEP : END4_STEP;
		hit = (cnt_inc == Q1_STEP) || (cnt_inc == Q2_STEP) || (cnt_inc == Q3_STEP)
			|| (cnt_inc == last_step);
		fclk.quarter = tick && hit;
		fclk.half    = tick && hit && (cnt_inc != Q1_STEP) && (cnt_inc != Q3_STEP);
		irq_set      = tick && hit && (cnt_inc == END4_STEP) && !mode_q[6];
		irq_inhibit_wr = frame_wr && wdata[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= '0;
		end else if (frame_wr) begin
			mode_q  <= wdata;
			count_q <= '0;
		end else if (tick) begin
			// wrap at the end of either sequence only when that step is active
			if (hit && (cnt_inc == END4_STEP || cnt_inc == END5_STEP))
				count_q <= '0;
			else
				count_q <= cnt_inc;
		end
	end
endmodule
`default_nettype wire

FILE: src/suc_pulse.sv
// One pulse channel: envelope, sweep, length counter and period gate.
`timescale 1ns / 1ps
`default_nettype none
module suc_pulse
	import suc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       ones_comp,
	input  wire logic       tick,
	input  wire frame_clk_t fclk,
	input  wire logic       enable,
	input  wire logic       wr,
	input  wire logic [1:0] wsel,
	input  wire logic [7:0] wdata,
	output logic [10:0]     period,
	output logic [1:0]      duty,
	output logic [3:0]      volume,
	output logic            len_nz
);
	logic [15:0] now_q, now_d;
	logic [10:0] base_q, base_d;
	logic [7:0]  len_q, len_d;
	logic [3:0]  envp_q, envp_d, envd_q, envd_d, lvl_q, lvl_d;
	logic [2:0]  swp_q, swp_d, swd_q, swd_d, sws_q, sws_d;
	logic [1:0]  duty_q, duty_d;
	logic [7:0]  fl_q, fl_d;
	logic [15:0] delta;

	always_comb begin
		now_d = now_q; base_d = base_q; len_d = len_q; envp_d = envp_q;
		envd_d = envd_q; lvl_d = lvl_q; swp_d = swp_q; swd_d = swd_q;
		sws_d = sws_q; duty_d = duty_q; fl_d = fl_q;
		delta = {5'd0, base_q >> sws_q};
		if (fl_q[3])
			delta = ones_comp ? ~delta : (16'd0 - delta);
		if (wr) begin
			case (wsel)
				2'd0: begin
					duty_d = wdata[7:6];
					fl_d[5:4] = wdata[5:4];
					envp_d = wdata[3:0];
				end
				2'd1: begin
					swp_d = wdata[6:4];
					fl_d[7] = wdata[7];
					fl_d[3] = wdata[3];
					fl_d[1] = 1'b1;
					sws_d = wdata[2:0];
				end
				2'd2: begin
					base_d = {base_q[10:8], wdata};
					now_d = {5'd0, base_d};
				end
				default: begin
					len_d = length_lookup(wdata[7:3]);
					base_d = {wdata[2:0], base_q[7:0]};
					now_d = {5'd0, base_d};
					fl_d[0] = 1'b1;
				end
			endcase
		end else if (tick) begin
			if (fclk.quarter) begin
				if (fl_q[0]) begin
					envd_d = envp_q; lvl_d = LEVEL_FULL; fl_d[0] = 1'b0;
				end else if (envd_q == 4'd0) begin
					if (lvl_q != 4'd0) lvl_d = lvl_q - 4'd1;
					else if (fl_q[5]) lvl_d = LEVEL_FULL;
					envd_d = envp_q;
				end else begin
					envd_d = envd_q - 4'd1;
				end
			end
			if (fclk.half) begin
				if (!fl_q[5] && len_q != 8'd0) len_d = len_q - 8'd1;
				if (swd_q == 3'd0 || fl_q[1]) begin
					if (swd_q == 3'd0 && fl_q[7]) now_d = now_q + delta;
					swd_d = swp_q;
					fl_d[1] = 1'b0;
				end else begin
					swd_d = swd_q - 3'd1;
				end
			end
			if (!enable) len_d = 8'd0;
			if (now_d < 16'd8 || now_d > PERIOD_MAX || len_d == 8'd0) now_d = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0; base_q <= '0; len_q <= '0; envp_q <= '0; envd_q <= '0;
			lvl_q <= '0; swp_q <= '0; swd_q <= '0; sws_q <= '0; duty_q <= '0; fl_q <= '0;
		end else begin
			now_q <= now_d; base_q <= base_d; len_q <= len_d; envp_q <= envp_d;
			envd_q <= envd_d; lvl_q <= lvl_d; swp_q <= swp_d; swd_q <= swd_d;
			sws_q <= sws_d; duty_q <= duty_d; fl_q <= fl_d;
		end
	end

	assign period = now_q[10:0];
	assign duty   = duty_q;
	assign volume = fl_q[4] ? envp_q : lvl_q;
	assign len_nz = len_q != 8'd0;
endmodule
`default_nettype wire

FILE: src/suc_tri_noise.sv
// Triangle and noise channels: lengths, linear counter, noise envelope.
`timescale 1ns / 1ps
`default_nettype none
module suc_tri_noise
	import suc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tick,
	input  wire frame_clk_t fclk,
	input  wire logic [1:0] enable,
	input  wire logic       wr,
	input  wire logic [4:0] waddr,
	input  wire logic [7:0] wdata,
	output logic [10:0]     tri_period,
	output logic            tri_active,
	output logic [11:0]     noise_period,
	output logic [3:0]      noise_volume,
	output logic [1:0]      len_nz
);
	logic [10:0] tper_q, tper_d;
	logic [7:0]  tlen_q, tlen_d;
	logic [6:0]  tlin_q, tlin_d, trel_q, trel_d;
	logic        tctl_q, tctl_d, trld_q, trld_d;
	logic [11:0] nper_q, nper_d;
	logic [7:0]  nlen_q, nlen_d;
	logic [3:0]  nenp_q, nenp_d, nend_q, nend_d, nlvl_q, nlvl_d;
	logic        nrld_q, nrld_d, ncv_q, ncv_d, nloop_q, nloop_d;

	always_comb begin
		tper_d = tper_q; tlen_d = tlen_q; tlin_d = tlin_q; trel_d = trel_q;
		tctl_d = tctl_q; trld_d = trld_q; nper_d = nper_q; nlen_d = nlen_q;
		nenp_d = nenp_q; nend_d = nend_q; nlvl_d = nlvl_q; nrld_d = nrld_q;
		ncv_d = ncv_q; nloop_d = nloop_q;
		if (wr) begin
			case (waddr)
				REG_TRI_LIN: begin
					tctl_d = wdata[7]; trld_d = 1'b1; trel_d = wdata[6:0];
				end
				REG_TRI_LO: tper_d = {tper_q[10:8], wdata};
				REG_TRI_HI: begin
					tlen_d = length_lookup(wdata[7:3]);
					tper_d = {wdata[2:0], tper_q[7:0]};
					trld_d = 1'b1;
				end
				REG_NS_CTRL: begin
					nloop_d = wdata[5]; ncv_d = wdata[4]; nenp_d = wdata[3:0];
				end
				REG_NS_PER: nper_d = noise_lookup(wdata[3:0]);
				REG_NS_LEN: begin
					nlen_d = length_lookup(wdata[7:3]); nrld_d = 1'b1;
				end
				default: ;
			endcase
		end else if (tick) begin
			if (fclk.quarter) begin
				if (trld_q) tlin_d = trel_q;
				else if (tlin_q != 7'd0) tlin_d = tlin_q - 7'd1;
				if (!tctl_q) trld_d = 1'b0;
				if (nrld_q) begin
					nend_d = nenp_q; nlvl_d = LEVEL_FULL; nrld_d = 1'b0;
				end else if (nend_q == 4'd0) begin
					if (nlvl_q != 4'd0) nlvl_d = nlvl_q - 4'd1;
					else if (nloop_q) nlvl_d = LEVEL_FULL;
					nend_d = nenp_q;
				end else begin
					nend_d = nend_q - 4'd1;
				end
			end
			if (fclk.half) begin
				if (!tctl_q && tlen_q != 8'd0) tlen_d = tlen_q - 8'd1;
				if (!nloop_q && nlen_q != 8'd0) nlen_d = nlen_q - 8'd1;
			end
			if (!enable[0]) tlen_d = 8'd0;
			if (!enable[1]) nlen_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tper_q <= '0; tlen_q <= '0; tlin_q <= '0; trel_q <= '0; tctl_q <= 1'b0;
			trld_q <= 1'b0; nper_q <= '0; nlen_q <= '0; nenp_q <= '0; nend_q <= '0;
			nlvl_q <= '0; nrld_q <= 1'b0; ncv_q <= 1'b0; nloop_q <= 1'b0;
		end else begin
			tper_q <= tper_d; tlen_q <= tlen_d; tlin_q <= tlin_d; trel_q <= trel_d;
			tctl_q <= tctl_d; trld_q <= trld_d; nper_q <= nper_d; nlen_q <= nlen_d;
			nenp_q <= nenp_d; nend_q <= nend_d; nlvl_q <= nlvl_d; nrld_q <= nrld_d;
			ncv_q <= ncv_d; nloop_q <= nloop_d;
		end
	end

	assign tri_period   = tper_q;
	assign tri_active   = (tlen_q != 8'd0) && (tlin_q != 7'd0);
	assign noise_period = nper_q;
	assign noise_volume = (nlen_q == 8'd0) ? 4'd0 : (ncv_q ? nenp_q : nlvl_q);
	assign len_nz       = {nlen_q != 8'd0, tlen_q != 8'd0};
endmodule
`default_nettype wire

FILE: src/sound_unit_register_and_frame_control_unit.sv
// Top level of the sound unit register and frame control block.
//
//  channel | dir | payload                         | handshake
//  req     | in  | op, reg_offset, write_data      | valid/ready
//  rsp     | out | read_data, irq_pulse, channels  | valid/ready
//
// One request per cycle: the state updates at the accepting edge and the
// response lands in an output register the next cycle. A request is taken
// whenever the output register is empty or being drained, so a stalled
// response holds back only the next request. Reset clears all state.
`timescale 1ns / 1ps
`default_nettype none
module sound_unit_register_and_frame_control_unit
	import suc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	suc_stream_if.sink   req,
	suc_stream_if.source rsp
);
	logic        take, tick, wr, rd_stat;
	logic [7:0]  status_q;
	logic        rvalid_q;
	logic [7:0]  rdata_s1;
	logic        irq_s1;
	frame_clk_t  fclk;
	logic        irq_set, irq_inh;
	logic [1:0]  pa_dummy;
	logic        len_a, len_b;
	logic [1:0]  tn_len;
	logic [10:0] pa_per, pb_per, t_per;
	logic [1:0]  pa_duty, pb_duty;
	logic [3:0]  pa_vol, pb_vol, n_vol;
	logic        t_act;
	logic [11:0] n_per;
	logic        wr_a, wr_b;

	assign req.ready = !rvalid_q || rsp.ready;
	assign take    = req.valid && req.ready;
	assign tick    = take && (req.data.op == OP_TICK);
	assign wr      = take && (req.data.op == OP_WRITE);
	assign rd_stat = take && (req.data.op == OP_READ) && (req.data.reg_offset == REG_STATUS);
	assign wr_a    = wr && (req.data.reg_offset[4:2] == 3'd0);
	assign wr_b    = wr && (req.data.reg_offset[4:2] == 3'd1);
	assign pa_dummy = req.data.reg_offset[1:0];

	suc_frame_seq u_seq (
		.clk, .arst_n, .tick,
		.frame_wr(wr && req.data.reg_offset == REG_FRAME),
		.wdata(req.data.write_data), .fclk, .irq_set, .irq_inhibit_wr(irq_inh)
	);

	suc_pulse u_pa (
		.clk, .arst_n, .ones_comp(1'b1), .tick, .fclk, .enable(status_q[0]),
		.wr(wr_a), .wsel(pa_dummy), .wdata(req.data.write_data),
		.period(pa_per), .duty(pa_duty), .volume(pa_vol), .len_nz(len_a)
	);

	suc_pulse u_pb (
		.clk, .arst_n, .ones_comp(1'b0), .tick, .fclk, .enable(status_q[1]),
		.wr(wr_b), .wsel(pa_dummy), .wdata(req.data.write_data),
		.period(pb_per), .duty(pb_duty), .volume(pb_vol), .len_nz(len_b)
	);

	suc_tri_noise u_tn (
		.clk, .arst_n, .tick, .fclk, .enable(status_q[3:2]), .wr,
		.waddr(req.data.reg_offset), .wdata(req.data.write_data),
		.tri_period(t_per), .tri_active(t_act), .noise_period(n_per),
		.noise_volume(n_vol), .len_nz(tn_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (take) rvalid_q <= 1'b1;
			else if (rsp.ready) rvalid_q <= 1'b0;
			if (wr && req.data.reg_offset == REG_STATUS)
				status_q <= {status_q[7:6], 1'b0, req.data.write_data[4:0]};
			else if (irq_inh || rd_stat)
				status_q[6] <= 1'b0;
			else if (irq_set)
				status_q[6] <= 1'b1;
		end
	end

	// read data and strobe are captured with the request; channel state is live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdata_s1 <= '0;
			irq_s1   <= 1'b0;
		end else if (take) begin
			rdata_s1 <= rd_stat ? {status_q[7:6], 2'b00, tn_len[1], tn_len[0], len_b, len_a}
				: 8'd0;
			irq_s1   <= irq_set;
		end
	end

	assign rsp.valid = rvalid_q;
	always_comb begin
		rsp.data.read_data      = rdata_s1;
		rsp.data.irq_pulse      = irq_s1;
		rsp.data.pulse_a_period = pa_per;
		rsp.data.pulse_b_period = pb_per;
		rsp.data.pulse_a_duty   = pa_duty;
		rsp.data.pulse_b_duty   = pb_duty;
		rsp.data.pulse_a_volume = pa_vol;
		rsp.data.pulse_b_volume = pb_vol;
		rsp.data.tri_period     = t_per;
		rsp.data.tri_active     = t_act;
		rsp.data.noise_period   = n_per;
		rsp.data.noise_volume   = n_vol;
	end
endmodule
`default_nettype wire

FILE: src/suc_checker.sv
// Port-level checks on the sound unit control block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module suc_checker
	import suc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req_data,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request produced no response");
	a_resp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");
	a_irq_tick: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.op != OP_TICK |=> !rsp_data.irq_pulse)
		else $error("interrupt on non-tick request");
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.op != OP_READ |=> rsp_data.read_data == 8'd0)
		else $error("read data on non-read request");
endmodule

bind sound_unit_register_and_frame_control_unit suc_checker u_chk (
	.clk, .arst_n,
	.req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire
